>>> src/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MKD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/mkd_pkg.sv
// Shared types, constants and the letter lookup for the Morse key decoder.
// No dependencies.
package mkd_pkg;

    localparam int TIME_W   = 16;
    localparam int CODE_W   = 6;
    localparam int CHAR_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] CNT_MAX = '1;

    localparam logic [TIME_W-1:0] DOT_LIMIT_RST  = 16'd500;
    localparam logic [TIME_W-1:0] DASH_LIMIT_RST = 16'd1500;
    localparam logic [TIME_W-1:0] LETTER_GAP_RST = 16'd1500;
    localparam logic [TIME_W-1:0] WORD_GAP_RST   = 16'd3500;

    localparam logic [CFG_IDX_W-1:0] REG_DOT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP   = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
    localparam logic [CODE_W-1:0] CODE_START = 6'd1;

    typedef struct packed {
        logic [TIME_W-1:0] dot_limit;
        logic [TIME_W-1:0] dash_limit;
        logic [TIME_W-1:0] letter_gap;
        logic [TIME_W-1:0] word_gap;
    } mkd_cfg_t;

    typedef struct packed {
        logic              dot_lamp;
        logic              dash_lamp;
        logic              letter_lamp;
        logic              word_lamp;
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
    } mkd_result_t;

    // Binary tree lookup: root is code 1, a dot shifts left, a dash shifts left and adds one.
    // Holes in the tree and codes past the table read as a space.
    function automatic logic [CHAR_W-1:0] mkd_letter(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            6'd2:    ch = 7'd101; // e
            6'd3:    ch = 7'd116; // t
            6'd4:    ch = 7'd105; // i
            6'd5:    ch = 7'd97;  // a
            6'd6:    ch = 7'd110; // n
            6'd7:    ch = 7'd109; // m
            6'd8:    ch = 7'd115; // s
            6'd9:    ch = 7'd117; // u
            6'd10:   ch = 7'd114; // r
            6'd11:   ch = 7'd119; // w
            6'd12:   ch = 7'd100; // d
            6'd13:   ch = 7'd107; // k
            6'd14:   ch = 7'd103; // g
            6'd15:   ch = 7'd111; // o
            6'd16:   ch = 7'd104; // h
            6'd17:   ch = 7'd118; // v
            6'd18:   ch = 7'd102; // f
            6'd20:   ch = 7'd108; // l
            6'd22:   ch = 7'd112; // p
            6'd23:   ch = 7'd106; // j
            6'd24:   ch = 7'd98;  // b
            6'd25:   ch = 7'd120; // x
            6'd26:   ch = 7'd99;  // c
            6'd27:   ch = 7'd121; // y
            6'd28:   ch = 7'd122; // z
            6'd29:   ch = 7'd113; // q
            default: ch = CHAR_SPACE;
        endcase
        return ch;
    endfunction

endpackage

>>> src/mkd_cfg_regs.sv
// Threshold register file for the Morse key decoder.
// Depends on mkd_pkg.
module mkd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [mkd_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [mkd_pkg::TIME_W-1:0]    wr_data,
    output mkd_pkg::mkd_cfg_t             cfg
);
    import mkd_pkg::*;

    mkd_cfg_t cfg_reg;
    mkd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DOT_LIMIT:  cfg_next.dot_limit  = wr_data;
                REG_DASH_LIMIT: cfg_next.dash_limit = wr_data;
                REG_LETTER_GAP: cfg_next.letter_gap = wr_data;
                REG_WORD_GAP:   cfg_next.word_gap   = wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_limit  <= DOT_LIMIT_RST;
            cfg_reg.dash_limit <= DASH_LIMIT_RST;
            cfg_reg.letter_gap <= LETTER_GAP_RST;
            cfg_reg.word_gap   <= WORD_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/mkd_core.sv
// Press/gap timing state and per-tick decode for the Morse key decoder.
// Depends on mkd_pkg.
module mkd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  key,
    input  mkd_pkg::mkd_cfg_t     cfg,
    output mkd_pkg::mkd_result_t  res
);
    import mkd_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_PRESS,
        PH_GAP
    } phase_t;

    phase_t              phase_reg,  phase_next;
    logic [TIME_W-1:0]   count_reg,  count_next;
    logic [CODE_W-1:0]   code_reg,   code_next;
    logic                ovf_reg,    ovf_next;
    logic                sent_reg,   sent_next;

    phase_t              phase_mid;
    logic [TIME_W-1:0]   count_mid;
    logic [CODE_W:0]     code_ext;

    always_comb
    begin
        phase_mid  = phase_reg;
        count_mid  = count_reg;
        code_next  = code_reg;
        ovf_next   = ovf_reg;
        sent_next  = sent_reg;
        count_next = count_reg;
        code_ext   = {1'b0, code_reg};
        res        = '0;

        // Phase change first, on the edge of the key level.
        unique case (phase_reg)
            PH_PRESS:
            begin
                if (!key)
                begin
                    if (count_reg > cfg.dot_limit)
                        code_ext = {code_reg, 1'b0};
                    if (count_reg > cfg.dash_limit)
                        code_ext = code_ext + 7'd1;
                    if (!ovf_reg)
                    begin
                        if (code_ext[CODE_W])
                            ovf_next = 1'b1;
                        else
                            code_next = code_ext[CODE_W-1:0];
                    end
                    count_mid = '0;
                    sent_next = 1'b0;
                    phase_mid = PH_GAP;
                end
            end
            PH_GAP:
            begin
                if (key)
                begin
                    if (count_reg > cfg.word_gap)
                    begin
                        res.char_valid = 1'b1;
                        res.char_code  = CHAR_SPACE;
                    end
                    count_mid = '0;
                    phase_mid = PH_PRESS;
                end
            end
            default:
            begin
                if (key)
                begin
                    count_mid = '0;
                    phase_mid = PH_PRESS;
                end
            end
        endcase

        // Count this tick, then drive lamps and the letter emission.
        if (phase_mid != PH_WAIT)
        begin
            count_next = (count_mid == CNT_MAX) ? count_mid : count_mid + 16'd1;
            if (phase_mid == PH_PRESS)
            begin
                res.dot_lamp  = count_next > cfg.dot_limit;
                res.dash_lamp = count_next > cfg.dash_limit;
            end
            else
            begin
                res.letter_lamp = count_next > cfg.letter_gap;
                res.word_lamp   = count_next > cfg.word_gap;
                if (res.letter_lamp && !sent_next)
                begin
                    res.char_valid = 1'b1;
                    res.char_code  = ovf_next ? CHAR_SPACE : mkd_letter(code_next);
                    code_next      = CODE_START;
                    ovf_next       = 1'b0;
                    sent_next      = 1'b1;
                end
            end
        end
        phase_next = phase_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            count_reg <= '0;
            code_reg  <= CODE_START;
            ovf_reg   <= 1'b0;
            sent_reg  <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            code_reg  <= code_next;
            ovf_reg   <= ovf_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

>>> src/morse_key_decoder_unit.sv
// Morse key decoder: one key sample per item, one result item per sample.
// An item is taken into the input register; its result item is loaded into the result
// register once that register is empty or being drained, and is offered from then on.
// Throughput: one item per cycle; the input register refills on the edge that moves
// its item on, so only a stalled, full result register holds off the sender.
// Reset: thresholds return to 500/1500/1500/3500, decoder waits for the first press.
module morse_key_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          key_down,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          dot_lamp,
    output logic                          dash_lamp,
    output logic                          letter_lamp,
    output logic                          word_lamp,
    output logic                          char_valid,
    output logic [mkd_pkg::CHAR_W-1:0]    char_code,
    // threshold write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mkd_pkg::TIME_W-1:0]    cfg_data
);
    import mkd_pkg::*;

    mkd_cfg_t    cfg;
    mkd_result_t res;
    mkd_result_t res_reg;

    logic in_valid_reg, in_valid_next;
    logic key_reg;
    logic out_valid_reg, out_valid_next;
    logic adv;
    logic take_in;

    // Thresholds are to be written only while idle; the block does not enforce this, so always accept.
    assign cfg_ready = 1'b1;

    mkd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held sample into the result register whenever that
    // register is empty or being drained this cycle.
    assign adv      = in_valid_reg && (!out_valid_reg || !out_stall);
    // Hold off the sender only while a sample sits in the input register
    // and cannot move on.
    assign in_stall = in_valid_reg && !adv;
    assign take_in  = in_valid && !in_stall;

    assign in_valid_next  = take_in || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && out_stall);

    mkd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .key   (key_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on acceptance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (take_in)
            key_reg <= key_down;
        if (adv)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign dot_lamp    = res_reg.dot_lamp;
    assign dash_lamp   = res_reg.dash_lamp;
    assign letter_lamp = res_reg.letter_lamp;
    assign word_lamp   = res_reg.word_lamp;
    assign char_valid  = res_reg.char_valid;
    assign char_code   = res_reg.char_code;

endmodule

>>> src/mkd_checker.sv
// Port-level checks for the Morse key decoder, bound to the top level.
// Depends on mkd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mkd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       dot_lamp,
    input logic                       dash_lamp,
    input logic                       letter_lamp,
    input logic                       word_lamp,
    input logic                       char_valid,
    input logic [mkd_pkg::CHAR_W-1:0] char_code
);
    import mkd_pkg::*;

    // Press lamps and gap lamps never light together.
    `MKD_ASSERT_NOW(a_lamp_phase, out_valid && (dot_lamp || dash_lamp), !letter_lamp && !word_lamp)

    // No character means a zero code.
    `MKD_ASSERT_NOW(a_idle_code, out_valid && !char_valid, char_code == '0)

    // A letter other than a space is only emitted past the letter time.
    `MKD_ASSERT_NOW(a_letter_gap, out_valid && char_valid && char_code != CHAR_SPACE, letter_lamp)

    // A stalled result stays put.
    `MKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(char_valid))

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (.*);
